### src/rdmc_pkg.sv
// Rover drive mode controller package: event codes, byte and pattern constants,
// configuration register indexes and the structs shared between the modules.
// No dependencies.
`default_nettype none

package rdmc_pkg;

  // Event kinds carried in the command field
  typedef enum logic [1:0] {
    CMD_RX_BYTE = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_ECHO    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_NEAR_THRESHOLD = 2'd0,
    CFG_DISTANCE_MAX   = 2'd1,
    CFG_STOP_TICKS     = 2'd2,
    CFG_TURN_TICKS     = 2'd3
  } cfg_index_t;

  // Avoidance sequence phases
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STOP = 2'd1,
    PH_TURN = 2'd2,
    PH_RSVD = 2'd3
  } phase_t;

  localparam int CfgDataW = 16;

  // Received command bytes
  localparam logic [7:0] BYTE_TOGGLE = 8'h43;
  localparam logic [7:0] BYTE_STOP   = 8'h51;
  localparam logic [7:0] BYTE_BACK   = 8'h53;
  localparam logic [7:0] BYTE_RIGHT  = 8'h44;
  localparam logic [7:0] BYTE_LEFT   = 8'h41;
  localparam logic [7:0] BYTE_FWD    = 8'h57;

  // Motor patterns
  localparam logic [3:0] MOT_STOP  = 4'h0;
  localparam logic [3:0] MOT_FWD   = 4'hA;
  localparam logic [3:0] MOT_BACK  = 4'h5;
  localparam logic [3:0] MOT_RIGHT = 4'h9;
  localparam logic [3:0] MOT_LEFT  = 4'h6;

  // Indicator patterns
  localparam logic [7:0] IND_IDLE  = 8'hFF;
  localparam logic [7:0] IND_FWD   = 8'h06;
  localparam logic [7:0] IND_BACK  = 8'h09;
  localparam logic [7:0] IND_RIGHT = 8'h0C;
  localparam logic [7:0] IND_LEFT  = 8'h03;

  // Configuration reset values
  localparam logic [7:0]  RST_NEAR_THRESHOLD = 8'd10;
  localparam logic [7:0]  RST_DISTANCE_MAX   = 8'd250;
  localparam logic [15:0] RST_STOP_TICKS     = 16'd1667;
  localparam logic [15:0] RST_TURN_TICKS     = 16'd8333;

  typedef struct packed {
    logic [7:0]  near_threshold;
    logic [7:0]  distance_max;
    logic [15:0] stop_ticks;
    logic [15:0] turn_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] motor_drive;
    logic [7:0] indicator;
    logic       auto_active;
    logic [7:0] distance_cm;
    logic       avoiding;
  } result_t;

endpackage

`default_nettype wire

### src/rdmc_cfg_regs.sv
// Configuration register bank of the rover drive mode controller.
// Depends on rdmc_pkg.
`default_nettype none

module rdmc_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [rdmc_pkg::CfgDataW-1:0] cfg_data,
  output rdmc_pkg::cfg_t                     cfg
);

  rdmc_pkg::cfg_index_t idx;
  assign idx = rdmc_pkg::cfg_index_t'(cfg_index);

  // Register writes, one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_threshold <= rdmc_pkg::RST_NEAR_THRESHOLD;
      cfg.distance_max   <= rdmc_pkg::RST_DISTANCE_MAX;
      cfg.stop_ticks     <= rdmc_pkg::RST_STOP_TICKS;
      cfg.turn_ticks     <= rdmc_pkg::RST_TURN_TICKS;
    end else if (cfg_wr_en) begin
      unique case (idx)
        rdmc_pkg::CFG_NEAR_THRESHOLD: cfg.near_threshold <= cfg_data[7:0];
        rdmc_pkg::CFG_DISTANCE_MAX:   cfg.distance_max   <= cfg_data[7:0];
        rdmc_pkg::CFG_STOP_TICKS:     cfg.stop_ticks     <= cfg_data;
        rdmc_pkg::CFG_TURN_TICKS:     cfg.turn_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/rdmc_state.sv
// Drive state registers and the single-cycle update for one event.
// Presents the result of the event being applied. Depends on rdmc_pkg.
`default_nettype none

module rdmc_state (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        echo_level,
  input  wire rdmc_pkg::cfg_t cfg,
  output rdmc_pkg::result_t result
);

  logic              auto_mode, auto_mode_next;
  logic [7:0]        held_byte, held_byte_next;
  logic [7:0]        echo_count, echo_count_next;
  logic [7:0]        latched_distance, latched_distance_next;
  logic              echo_previous, echo_previous_next;
  logic [3:0]        motor_state, motor_state_next;
  logic [7:0]        indicator_state, indicator_state_next;
  rdmc_pkg::phase_t  avoid_phase, avoid_phase_next;
  logic [15:0]       avoid_timer, avoid_timer_next;

  rdmc_pkg::cmd_t cmd;
  logic           was_idle;
  logic [8:0]     count_inc;

  assign cmd      = rdmc_pkg::cmd_t'(command);
  assign was_idle = (avoid_phase == rdmc_pkg::PH_IDLE);

  // Echo count candidate: restart at 1 on a rising edge, else count up
  assign count_inc = echo_previous ? ({1'b0, echo_count} + 9'd1) : 9'd1;

  // Next state for the event
  always_comb begin
    auto_mode_next        = auto_mode;
    held_byte_next        = held_byte;
    echo_count_next       = echo_count;
    latched_distance_next = latched_distance;
    echo_previous_next    = echo_previous;
    motor_state_next      = motor_state;
    indicator_state_next  = indicator_state;
    avoid_phase_next      = avoid_phase;
    avoid_timer_next      = avoid_timer;

    unique case (cmd)
      rdmc_pkg::CMD_RX_BYTE: begin
        held_byte_next = rx_byte;
        // mode toggle stops the motors and aborts avoidance
        if (rx_byte == rdmc_pkg::BYTE_TOGGLE) begin
          auto_mode_next   = ~auto_mode;
          motor_state_next = rdmc_pkg::MOT_STOP;
          avoid_phase_next = rdmc_pkg::PH_IDLE;
          avoid_timer_next = '0;
        end
      end

      rdmc_pkg::CMD_TICK: begin
        if (!auto_mode) begin
          unique case (held_byte)
            rdmc_pkg::BYTE_STOP: begin
              motor_state_next     = rdmc_pkg::MOT_STOP;
              indicator_state_next = rdmc_pkg::IND_IDLE;
            end
            rdmc_pkg::BYTE_BACK: begin
              motor_state_next     = rdmc_pkg::MOT_BACK;
              indicator_state_next = rdmc_pkg::IND_BACK;
            end
            rdmc_pkg::BYTE_RIGHT: begin
              motor_state_next     = rdmc_pkg::MOT_RIGHT;
              indicator_state_next = rdmc_pkg::IND_RIGHT;
            end
            rdmc_pkg::BYTE_LEFT: begin
              motor_state_next     = rdmc_pkg::MOT_LEFT;
              indicator_state_next = rdmc_pkg::IND_LEFT;
            end
            rdmc_pkg::BYTE_FWD: begin
              // forward refused when the obstacle is near
              if (latched_distance > cfg.near_threshold) begin
                motor_state_next     = rdmc_pkg::MOT_FWD;
                indicator_state_next = rdmc_pkg::IND_FWD;
              end else begin
                motor_state_next     = rdmc_pkg::MOT_STOP;
                indicator_state_next = rdmc_pkg::IND_IDLE;
              end
            end
            default: ;
          endcase
        end
      end

      rdmc_pkg::CMD_ECHO: begin
        // avoidance sequence timing
        if (!was_idle) begin
          if (avoid_timer != 16'd0) begin
            avoid_timer_next = avoid_timer - 16'd1;
          end else if (avoid_phase == rdmc_pkg::PH_STOP) begin
            avoid_phase_next = rdmc_pkg::PH_TURN;
            motor_state_next = rdmc_pkg::MOT_LEFT;
            avoid_timer_next = cfg.turn_ticks;
          end else begin
            avoid_phase_next = rdmc_pkg::PH_IDLE;
            motor_state_next = rdmc_pkg::MOT_STOP;
          end
        end

        // pulse width measurement and latch on the falling edge
        if (echo_level) begin
          if (count_inc > {1'b0, cfg.distance_max}) begin
            echo_count_next = cfg.distance_max;
          end else begin
            echo_count_next = count_inc[7:0];
          end
        end else if (echo_previous) begin
          latched_distance_next = echo_count;
          if (auto_mode && was_idle) begin
            if (echo_count > cfg.near_threshold) begin
              motor_state_next = rdmc_pkg::MOT_FWD;
            end else begin
              motor_state_next = rdmc_pkg::MOT_STOP;
              avoid_phase_next = rdmc_pkg::PH_STOP;
              avoid_timer_next = cfg.stop_ticks;
            end
          end
        end
        echo_previous_next = echo_level;
      end

      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mode        <= 1'b0;
      held_byte        <= '0;
      echo_count       <= '0;
      latched_distance <= '0;
      echo_previous    <= 1'b0;
      motor_state      <= rdmc_pkg::MOT_STOP;
      indicator_state  <= rdmc_pkg::IND_IDLE;
      avoid_phase      <= rdmc_pkg::PH_IDLE;
      avoid_timer      <= '0;
    end else if (step) begin
      auto_mode        <= auto_mode_next;
      held_byte        <= held_byte_next;
      echo_count       <= echo_count_next;
      latched_distance <= latched_distance_next;
      echo_previous    <= echo_previous_next;
      motor_state      <= motor_state_next;
      indicator_state  <= indicator_state_next;
      avoid_phase      <= avoid_phase_next;
      avoid_timer      <= avoid_timer_next;
    end
  end

  // Result reflects the state after the event
  always_comb begin
    result.motor_drive = motor_state_next;
    result.indicator   = indicator_state_next;
    result.auto_active = auto_mode_next;
    result.distance_cm = latched_distance_next;
    result.avoiding    = (avoid_phase_next != rdmc_pkg::PH_IDLE);
  end

endmodule

`default_nettype wire

### src/rover_drive_mode_controller.sv
// Top level of the rover drive mode controller: request input register,
// result register and the state update. Depends on rdmc_pkg, rdmc_cfg_regs, rdmc_state.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------------------
//   in       | input     | in_valid / in_stall  | command, rx_byte, echo_level
//   out      | output    | out_valid / out_stall| motor_drive, indicator, auto_active,
//            |           |                      | distance_cm, avoiding
//   cfg      | input     | cfg_wr_en            | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; each taken request is held in the input
// register until the result register is free, then the state update writes its result there.
// Synchronous reset clears the state and configuration to their defaults; the block
// takes a request in the first cycle after reset.
// A stalled result holds while one more request waits in the input register; in_stall
// rises only when both are full.
`default_nettype none

module rover_drive_mode_controller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    command,
  input  wire logic [7:0]                    rx_byte,
  input  wire logic                          echo_level,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [3:0]                         motor_drive,
  output logic [7:0]                         indicator,
  output logic                               auto_active,
  output logic [7:0]                         distance_cm,
  output logic                               avoiding,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [rdmc_pkg::CfgDataW-1:0] cfg_data
);

  rdmc_pkg::cfg_t    cfg;
  rdmc_pkg::result_t result;

  logic       req_valid;
  logic [1:0] req_command;
  logic [7:0] req_rx_byte;
  logic       req_echo_level;
  logic       advance;

  // A held request moves on when the result register is free or draining
  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !advance;

  rdmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      req_command    <= command;
      req_rx_byte    <= rx_byte;
      req_echo_level <= echo_level;
    end
  end

  rdmc_state u_state (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .command    (req_command),
    .rx_byte    (req_rx_byte),
    .echo_level (req_echo_level),
    .cfg        (cfg),
    .result     (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      motor_drive <= result.motor_drive;
      indicator   <= result.indicator;
      auto_active <= result.auto_active;
      distance_cm <= result.distance_cm;
      avoiding    <= result.avoiding;
    end
  end

endmodule

`default_nettype wire

### tb/rdmc_checker.sv
`timescale 1ns / 1ps
// Checker for the rover drive mode controller. It watches the request, result and register
// write ports, predicts each result and compares it field by field. Depends on rdmc_pkg.
module rdmc_checker
  import rdmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          command,
  input  logic [7:0]          rx_byte,
  input  logic                echo_level,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [3:0]          motor_drive,
  input  logic [7:0]          indicator,
  input  logic                auto_active,
  input  logic [7:0]          distance_cm,
  input  logic                avoiding,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatches,
  output int                  pending,
  output int                  results_checked,
  output int                  sequences_started
);

  // Predicted copy of the register file
  logic [7:0]  near_cm;
  logic [7:0]  max_cm;
  logic [15:0] stop_len;
  logic [15:0] turn_len;

  // Predicted copy of the controller state
  logic        mode_auto;
  logic [7:0]  kept_byte;
  logic [7:0]  pulse_count;
  logic [7:0]  last_distance;
  logic        echo_was_high;
  logic [3:0]  motor_now;
  logic [7:0]  indicator_now;
  phase_t      phase_now;
  logic [15:0] phase_timer;

  result_t expected_status[$];
  result_t got;
  result_t want;

  initial begin
    mismatches = 0;
    pending = 0;
    results_checked = 0;
    sequences_started = 0;
  end

  task automatic reset_model();
    near_cm       = RST_NEAR_THRESHOLD;
    max_cm        = RST_DISTANCE_MAX;
    stop_len      = RST_STOP_TICKS;
    turn_len      = RST_TURN_TICKS;
    mode_auto     = 1'b0;
    kept_byte     = 8'd0;
    pulse_count   = 8'd0;
    last_distance = 8'd0;
    echo_was_high = 1'b0;
    motor_now     = MOT_STOP;
    indicator_now = IND_IDLE;
    phase_now     = PH_IDLE;
    phase_timer   = 16'd0;
  endtask

  task automatic flag_mismatch(input string what, input int seen, input int wanted);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
             $time, what, seen, wanted, results_checked);
  endtask

  // Manual-mode control tick: map the kept byte to a drive pattern
  function automatic void manual_drive();
    case (kept_byte)
      BYTE_STOP: begin
        motor_now = MOT_STOP;
        indicator_now = IND_IDLE;
      end
      BYTE_BACK: begin
        motor_now = MOT_BACK;
        indicator_now = IND_BACK;
      end
      BYTE_RIGHT: begin
        motor_now = MOT_RIGHT;
        indicator_now = IND_RIGHT;
      end
      BYTE_LEFT: begin
        motor_now = MOT_LEFT;
        indicator_now = IND_LEFT;
      end
      BYTE_FWD: begin
        // forward refused while the obstacle is near
        if (last_distance > near_cm) begin
          motor_now = MOT_FWD;
          indicator_now = IND_FWD;
        end else begin
          motor_now = MOT_STOP;
          indicator_now = IND_IDLE;
        end
      end
      default: ;
    endcase
  endfunction

  // Echo sample: advance the avoidance sequence, then measure the pulse
  function automatic void echo_sample(input logic lvl);
    logic was_idle;
    int   next_count;
    was_idle = (phase_now == PH_IDLE);
    if (!was_idle) begin
      if (phase_timer != 16'd0) begin
        phase_timer = phase_timer - 16'd1;
      end else if (phase_now == PH_STOP) begin
        phase_now = PH_TURN;
        motor_now = MOT_LEFT;
        phase_timer = turn_len;
      end else begin
        phase_now = PH_IDLE;
        motor_now = MOT_STOP;
      end
    end
    if (lvl) begin
      next_count = echo_was_high ? int'(pulse_count) + 1 : 1;
      if (next_count > int'(max_cm))
        next_count = int'(max_cm);
      pulse_count = next_count[7:0];
    end else if (echo_was_high) begin
      // falling edge latches the distance; in auto mode it drives the decision
      last_distance = pulse_count;
      if (mode_auto && was_idle) begin
        if (last_distance > near_cm) begin
          motor_now = MOT_FWD;
        end else begin
          motor_now = MOT_STOP;
          phase_now = PH_STOP;
          phase_timer = stop_len;
          sequences_started++;
        end
      end
    end
    echo_was_high = lvl;
  endfunction

  function automatic result_t rover_step(input cmd_t cmd, input logic [7:0] rx, input logic lvl);
    result_t r;
    case (cmd)
      CMD_RX_BYTE: begin
        kept_byte = rx;
        // mode toggle stops the motors and aborts any sequence
        if (rx == BYTE_TOGGLE) begin
          mode_auto = ~mode_auto;
          motor_now = MOT_STOP;
          phase_now = PH_IDLE;
          phase_timer = 16'd0;
        end
      end
      CMD_TICK: if (!mode_auto) manual_drive();
      CMD_ECHO: echo_sample(lvl);
      default: ;
    endcase
    r.motor_drive = motor_now;
    r.indicator   = indicator_now;
    r.auto_active = mode_auto;
    r.distance_cm = last_distance;
    r.avoiding    = (phase_now != PH_IDLE);
    return r;
  endfunction

  // Register writes, result checks and request prediction
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      expected_status.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index_t'(cfg_index))
          CFG_NEAR_THRESHOLD: near_cm  = cfg_data[7:0];
          CFG_DISTANCE_MAX:   max_cm   = cfg_data[7:0];
          CFG_STOP_TICKS:     stop_len = cfg_data[15:0];
          CFG_TURN_TICKS:     turn_len = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.motor_drive = motor_drive;
        got.indicator   = indicator;
        got.auto_active = auto_active;
        got.distance_cm = distance_cm;
        got.avoiding    = avoiding;
        if (expected_status.size() == 0) begin
          flag_mismatch("unexpected result", int'(got), 0);
        end else begin
          want = expected_status.pop_front();
          if (got.motor_drive !== want.motor_drive)
            flag_mismatch("motor_drive", got.motor_drive, want.motor_drive);
          if (got.indicator !== want.indicator)
            flag_mismatch("indicator", got.indicator, want.indicator);
          if (got.auto_active !== want.auto_active)
            flag_mismatch("auto_active", got.auto_active, want.auto_active);
          if (got.distance_cm !== want.distance_cm)
            flag_mismatch("distance_cm", got.distance_cm, want.distance_cm);
          if (got.avoiding !== want.avoiding)
            flag_mismatch("avoiding", got.avoiding, want.avoiding);
        end
        results_checked++;
      end
      if (in_valid && !in_stall)
        expected_status.push_back(rover_step(cmd_t'(command), rx_byte, echo_level));
    end
    pending = expected_status.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the rover drive mode controller testbench: clock, reset, request and stall
// generation, register settings and the verdict. Depends on rdmc_pkg and rdmc_checker.
module testbench;
  import rdmc_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 80;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          command;
  logic [7:0]          rx_byte;
  logic                echo_level;
  logic                out_valid;
  logic                out_stall;
  logic [3:0]          motor_drive;
  logic [7:0]          indicator;
  logic                auto_active;
  logic [7:0]          distance_cm;
  logic                avoiding;
  logic                cfg_wr_en;
  logic [1:0]          cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int   mismatches;
  int   pending;
  int   results_checked;
  int   sequences_started;
  int   cycle_count = 0;
  int   requests_sent = 0;
  int   phase_requests = 0;
  int   settings_used = 0;
  logic accepted_q = 1'b0;
  logic quiet;
  logic hold_req;
  logic hold_done = 1'b0;

  logic [7:0] drive_bytes [5] = '{BYTE_STOP, BYTE_BACK, BYTE_RIGHT, BYTE_LEFT, BYTE_FWD};

  rover_drive_mode_controller u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .rx_byte(rx_byte), .echo_level(echo_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .motor_drive(motor_drive), .indicator(indicator), .auto_active(auto_active),
    .distance_cm(distance_cm), .avoiding(avoiding),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rdmc_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .rx_byte(rx_byte), .echo_level(echo_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .motor_drive(motor_drive), .indicator(indicator), .auto_active(auto_active),
    .distance_cm(distance_cm), .avoiding(avoiding),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending),
    .results_checked(results_checked), .sequences_started(sequences_started)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Request acceptance as seen at the edge, plus the run watchdog
  always @(posedge clk) begin
    accepted_q <= in_valid && !in_stall && !rst;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off, none when quiet
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  // Offer one request and hold it until taken; entered at a falling edge
  task automatic send_request(input cmd_t cmd, input logic [7:0] rx, input logic lvl);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    rx_byte <= rx;
    echo_level <= lvl;
    @(negedge clk);
    while (!accepted_q) @(negedge clk);
    if (cmd != CMD_NONE) begin
      phase_requests++;
      requests_sent++;
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(CMD_RX_BYTE, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_tick();
    send_request(CMD_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_echo(input logic lvl);
    send_request(CMD_ECHO, 8'($urandom), lvl);
  endtask

  // Echo pulse: a run of high samples closed by one low sample
  task automatic send_pulse(input int highs);
    repeat (highs) send_echo(1'b1);
    send_echo(1'b0);
  endtask

  // Let every outstanding result drain, then allow the pipeline to empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] near_cm, input logic [7:0] max_cm,
                           input logic [15:0] stop_len, input logic [15:0] turn_len);
    settle();
    write_reg(CFG_NEAR_THRESHOLD, {8'd0, near_cm});
    write_reg(CFG_DISTANCE_MAX, {8'd0, max_cm});
    write_reg(CFG_STOP_TICKS, stop_len);
    write_reg(CFG_TURN_TICKS, turn_len);
    settings_used++;
  endtask

  // Random traffic: mostly echo pulses and drive commands, with toggles and noise
  task automatic run_traffic(input int budget);
    int pick;
    phase_requests = 0;
    while (phase_requests < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        send_pulse($urandom_range(0, 14));
      end else if (pick < 58) begin
        send_byte(drive_bytes[$urandom_range(0, 4)]);
        repeat ($urandom_range(1, 2)) send_tick();
      end else if (pick < 67) begin
        send_byte(BYTE_TOGGLE);
      end else if (pick < 77) begin
        send_tick();
      end else if (pick < 87) begin
        send_byte(8'($urandom));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 10)) send_echo(1'b0);
      end else begin
        send_request(CMD_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_RX_BYTE;
    rx_byte = 8'd0;
    echo_level = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_NEAR_THRESHOLD;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every drive byte, refused forward, unknown bytes, auto mode and abort
    send_tick();
    send_request(CMD_NONE, 8'hA5, 1'b1);
    send_byte(BYTE_FWD);
    send_tick();
    send_byte(BYTE_BACK);
    send_tick();
    send_byte(BYTE_STOP);
    send_tick();
    send_byte(BYTE_RIGHT);
    send_tick();
    send_byte(BYTE_LEFT);
    send_tick();
    send_byte(8'hFF);
    send_tick();
    send_byte(BYTE_TOGGLE);
    send_tick();
    send_echo(1'b1);
    send_echo(1'b0);
    send_echo(1'b0);
    send_byte(BYTE_TOGGLE);
    send_byte(8'h00);
    send_tick();

    // Random phases over several register settings
    configure(8'd10, 8'd250, 16'd3, 16'd5);
    hold_req = 1'b1;
    run_traffic(80);
    configure(8'd0, 8'd1, 16'd0, 16'd0);
    run_traffic(70);
    configure(8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    send_pulse(258);
    run_traffic(60);
    repeat (2) begin
      configure(8'($urandom_range(0, 20)), 8'($urandom_range(1, 24)),
                16'($urandom_range(0, 6)), 16'($urandom_range(0, 9)));
      run_traffic(70);
    end
    configure(8'd12, 8'd40, 16'd2, 16'd3);
    quiet = 1'b1;
    run_traffic(70);

    settle();
    repeat (8) @(negedge clk);
    $display("Covered %0d requests over %0d register settings and the reset defaults;",
             requests_sent, settings_used);
    $display("%0d results checked, %0d avoidance sequences started.",
             results_checked, sequences_started);
    if (mismatches == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
src/rdmc_pkg.sv
src/rdmc_cfg_regs.sv
src/rdmc_state.sv
src/rover_drive_mode_controller.sv
tb/rdmc_checker.sv
tb/testbench.sv
